// ===== src/nds_pkg.sv =====
package nds_pkg;

    localparam int MAX_SOURCE_DIM = 8000;
    localparam int MAX_TARGET_DIM = 512;

    localparam int DIM_W   = 13;
    localparam int TGT_W   = 10;
    localparam int COMP_W  = 2;
    localparam int ACC_W   = 22;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIM_W-1:0]  RESET_WIDTH  = DIM_W'(512);
    localparam logic [DIM_W-1:0]  RESET_HEIGHT = DIM_W'(512);
    localparam logic [TGT_W-1:0]  RESET_TARGET = TGT_W'(MAX_TARGET_DIM);
    localparam logic [COMP_W-1:0] RESET_COMPS  = COMP_W'(3);

    localparam logic [7:0] RED_MASK   = 8'hF8;
    localparam logic [7:0] GREEN_MASK = 8'hFC;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH    = CFG_IDX_W'(0),
        REG_SOURCE_HEIGHT   = CFG_IDX_W'(1),
        REG_TARGET_SIZE     = CFG_IDX_W'(2),
        REG_COMPONENT_COUNT = CFG_IDX_W'(3)
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0]  source_width;
        logic [DIM_W-1:0]  source_height;
        logic [TGT_W-1:0]  target_size;
        logic [COMP_W-1:0] component_count;
        logic              size_bad;
    } cfg_t;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
        logic size_error;
    } scan_res_t;

    function automatic logic [15:0] pack565(
        input logic [7:0]        r,
        input logic [7:0]        g,
        input logic [7:0]        b,
        input logic [COMP_W-1:0] comps
    );
        logic [7:0] gs;
        logic [7:0] bs;
        gs = (comps < COMP_W'(2)) ? r : g;
        bs = (comps < COMP_W'(3)) ? r : b;
        return {r[7:3] & RED_MASK[7:3], gs[7:2] & GREEN_MASK[7:2], bs[7:3]};
    endfunction

endpackage

// ===== src/nds_if.sv =====
interface nds_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface nds_pix_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel565;
    logic        row_end;
    logic        frame_end;
    logic        size_error;

    modport source (output valid, output pixel565, output row_end, output frame_end,
                    output size_error, input ready);
    modport sink   (input valid, input pixel565, input row_end, input frame_end,
                    input size_error, output ready);
endinterface

interface nds_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [nds_pkg::CFG_IDX_W-1:0] index;
    logic [nds_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/nds_cfg.sv =====
module nds_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    nds_cfg_if.sink                    cfg,
    output nds_pkg::cfg_t              cfg_out,
    output logic                       restart,
    output logic [nds_pkg::TGT_W-1:0]  restart_target
);
    import nds_pkg::*;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [TGT_W-1:0]  target_reg;
    logic [COMP_W-1:0] comps_reg;
    logic              wr;

    assign cfg.ready = 1'b1;
    assign wr = cfg.valid && cfg.ready;

    // the restarted frame starts from the target being written in the same cycle
    assign restart_target = (wr && (cfg.index == REG_TARGET_SIZE))
        ? cfg.data[TGT_W-1:0] : target_reg;

    always_comb
    begin
        restart = 1'b0;
        if (wr)
        begin
            unique case (cfg.index)
                REG_SOURCE_WIDTH,
                REG_SOURCE_HEIGHT,
                REG_TARGET_SIZE,
                REG_COMPONENT_COUNT: restart = 1'b1;
                default:             restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            target_reg <= RESET_TARGET;
            comps_reg  <= RESET_COMPS;
        end
        else if (wr)
        begin
            unique case (cfg.index)
                REG_SOURCE_WIDTH:    width_reg  <= cfg.data[DIM_W-1:0];
                REG_SOURCE_HEIGHT:   height_reg <= cfg.data[DIM_W-1:0];
                REG_TARGET_SIZE:     target_reg <= cfg.data[TGT_W-1:0];
                REG_COMPONENT_COUNT: comps_reg  <= cfg.data[COMP_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        cfg_out.source_width    = width_reg;
        cfg_out.source_height   = height_reg;
        cfg_out.target_size     = target_reg;
        cfg_out.component_count = comps_reg;
        cfg_out.size_bad = (target_reg == '0)
            || ({1'b0, target_reg} > (TGT_W+1)'(MAX_TARGET_DIM))
            || ({1'b0, width_reg}  > (DIM_W+1)'(MAX_SOURCE_DIM))
            || ({1'b0, height_reg} > (DIM_W+1)'(MAX_SOURCE_DIM))
            || (width_reg  < DIM_W'(target_reg))
            || (height_reg < DIM_W'(target_reg));
    end

endmodule

// ===== src/nds_scan.sv =====
module nds_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nds_pkg::cfg_t              cfg_in,
    input  logic                       restart,
    input  logic [nds_pkg::TGT_W-1:0]  restart_target,
    input  logic                       step,
    output nds_pkg::scan_res_t         res
);
    import nds_pkg::*;

    logic [DIM_W-1:0] src_col_reg, src_col_next;
    logic [DIM_W-1:0] src_row_reg, src_row_next;
    logic [TGT_W-1:0] out_col_reg, out_col_next;
    logic [TGT_W-1:0] out_row_reg, out_row_next;
    logic [ACC_W-1:0] col_pos_reg, col_pos_next;
    logic [ACC_W-1:0] col_bnd_reg, col_bnd_next;
    logic [ACC_W-1:0] row_pos_reg, row_pos_next;
    logic [ACC_W-1:0] row_bnd_reg, row_bnd_next;
    logic             row_sel_reg, row_sel_next;

    logic [ACC_W-1:0] t_acc;
    logic [TGT_W-1:0] t_last;
    logic             sel_now;
    logic             row_last;
    logic             frame_last;
    logic             emit;

    assign t_acc  = ACC_W'(cfg_in.target_size);
    assign t_last = cfg_in.target_size - TGT_W'(1);

    // row choice is made on the first column and held for the rest of the row
    assign sel_now = (src_col_reg == '0)
        ? ((row_pos_reg < row_bnd_reg) && (out_row_reg < cfg_in.target_size))
        : row_sel_reg;

    assign emit = !cfg_in.size_bad && sel_now
        && (out_col_reg < cfg_in.target_size) && (col_pos_reg < col_bnd_reg);

    assign row_last   = ({1'b0, src_col_reg} + (DIM_W+1)'(1)) >= {1'b0, cfg_in.source_width};
    assign frame_last = ({1'b0, src_row_reg} + (DIM_W+1)'(1)) >= {1'b0, cfg_in.source_height};

    always_comb
    begin
        res.emit       = emit;
        res.row_end    = emit && (out_col_reg == t_last);
        res.frame_end  = emit && (out_col_reg == t_last) && (out_row_reg == t_last);
        res.size_error = cfg_in.size_bad;
    end

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        col_pos_next = col_pos_reg;
        col_bnd_next = col_bnd_reg;
        row_pos_next = row_pos_reg;
        row_bnd_next = row_bnd_reg;
        row_sel_next = row_sel_reg;

        if (restart)
        begin
            src_col_next = '0;
            src_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
            col_pos_next = '0;
            row_pos_next = '0;
            col_bnd_next = ACC_W'(restart_target);
            row_bnd_next = ACC_W'(restart_target);
            row_sel_next = 1'b0;
        end
        else if (step && !cfg_in.size_bad)
        begin
            if (emit)
            begin
                out_col_next = out_col_reg + TGT_W'(1);
                col_pos_next = col_pos_reg + ACC_W'(cfg_in.source_width);
            end
            if (row_last)
            begin
                src_col_next = '0;
                out_col_next = '0;
                col_pos_next = '0;
                col_bnd_next = t_acc;
                row_sel_next = 1'b0;
                if (frame_last)
                begin
                    src_row_next = '0;
                    out_row_next = '0;
                    row_pos_next = '0;
                    row_bnd_next = t_acc;
                end
                else
                begin
                    src_row_next = src_row_reg + DIM_W'(1);
                    row_bnd_next = row_bnd_reg + t_acc;
                    if (sel_now)
                    begin
                        out_row_next = out_row_reg + TGT_W'(1);
                        row_pos_next = row_pos_reg + ACC_W'(cfg_in.source_height);
                    end
                end
            end
            else
            begin
                src_col_next = src_col_reg + DIM_W'(1);
                col_bnd_next = col_bnd_reg + t_acc;
                row_sel_next = sel_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_pos_reg <= '0;
            col_bnd_reg <= ACC_W'(RESET_TARGET);
            row_pos_reg <= '0;
            row_bnd_reg <= ACC_W'(RESET_TARGET);
            row_sel_reg <= 1'b0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            col_pos_reg <= col_pos_next;
            col_bnd_reg <= col_bnd_next;
            row_pos_reg <= row_pos_next;
            row_bnd_reg <= row_bnd_next;
            row_sel_reg <= row_sel_next;
        end
    end

endmodule

// ===== src/nearest_downscale_rgb565.sv =====
// Nearest-neighbor square downscaler: source pixels come in raster order, one item per
// cycle, and a target_size x target_size grid of RGB565 pixels leaves in raster order,
// with row_end and frame_end marking the last pixel of each output row and of the frame.
// Source pixels that are not selected give no item. An item passes an input register and
// a result register, and the block takes a new pixel every cycle as long as the result
// side keeps up; the position accumulators advance by one add and compare per pixel. If
// the source is smaller than the target or a size is out of range, every pixel yields one
// item with size_error set and the scan does not advance. A write to any of the four
// configuration registers restarts the frame.
module nearest_downscale_rgb565 (
    input  logic          clk,
    input  logic          rst_n,
    nds_pix_in_if.sink    src_pix,
    nds_pix_out_if.source dst_pix,
    nds_cfg_if.sink       cfg
);
    import nds_pkg::*;

    cfg_t      cfg_cur;
    scan_res_t res;
    logic      restart;
    logic [TGT_W-1:0] restart_target;

    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_red_reg;
    logic [7:0] a_green_reg;
    logic [7:0] a_blue_reg;

    logic        b_valid_reg, b_valid_next;
    logic [15:0] b_pixel_reg;
    logic        b_row_end_reg;
    logic        b_frame_end_reg;
    logic        b_error_reg;

    logic b_free;
    logic has_result;
    logic a_go;
    logic take;
    logic produce;

    nds_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cfg_out        (cfg_cur),
        .restart        (restart),
        .restart_target (restart_target)
    );

    nds_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_in         (cfg_cur),
        .restart        (restart),
        .restart_target (restart_target),
        .step           (a_go),
        .res            (res)
    );

    assign b_free     = !b_valid_reg || dst_pix.ready;
    assign has_result = res.emit || res.size_error;
    // an unselected pixel leaves without waiting on the result side
    assign a_go       = a_valid_reg && (!has_result || b_free);
    assign produce    = a_go && has_result;
    assign src_pix.ready = !a_valid_reg || a_go;
    assign take       = src_pix.valid && src_pix.ready;

    assign a_valid_next = take ? 1'b1 : (a_go ? 1'b0 : a_valid_reg);
    assign b_valid_next = produce ? 1'b1 : (dst_pix.ready ? 1'b0 : b_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_red_reg   <= src_pix.red;
            a_green_reg <= src_pix.green;
            a_blue_reg  <= src_pix.blue;
        end
        if (produce)
        begin
            b_pixel_reg     <= res.size_error ? 16'h0000
                : pack565(a_red_reg, a_green_reg, a_blue_reg, cfg_cur.component_count);
            b_row_end_reg   <= res.row_end && !res.size_error;
            b_frame_end_reg <= res.frame_end && !res.size_error;
            b_error_reg     <= res.size_error;
        end
    end

    assign dst_pix.valid      = b_valid_reg;
    assign dst_pix.pixel565   = b_pixel_reg;
    assign dst_pix.row_end    = b_row_end_reg;
    assign dst_pix.frame_end  = b_frame_end_reg;
    assign dst_pix.size_error = b_error_reg;

endmodule
